FILE: sv/pfe_pkg.sv
package pfe_pkg;

	localparam int FUNC_W  = 2;
	localparam int FNUM_W  = 28;
	localparam int WIRE_W  = 3;
	localparam int KEY_W   = FNUM_W + WIRE_W;
	localparam int VALUE_W = 32;
	localparam int BYTE_W  = 8;
	localparam int GROUP_W = 7;

	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_VARINT = 2'd0,
		FUNC_LEN    = 2'd1,
		FUNC_BYTE   = 2'd2
	} func_t;

	localparam logic [WIRE_W-1:0] WIRE_VARINT = 3'd0;
	localparam logic [WIRE_W-1:0] WIRE_LEN    = 3'd2;

	typedef enum logic {
		CMD_FIELD = 1'b0,
		CMD_BYTE  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_KEY  = 2'd1,
		ST_VAL  = 2'd2
	} ser_state_t;

endpackage

FILE: sv/pfe_ifs.sv
interface pfe_in_if;
	import pfe_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [FNUM_W-1:0]   fnum;
	logic [VALUE_W-1:0]  value;
	logic [BYTE_W-1:0]   payload_byte;

	modport source (output valid, output func, output fnum, output value,
		output payload_byte, input ready);
	modport sink (input valid, input func, input fnum, input value,
		input payload_byte, output ready);
endinterface

interface pfe_out_if;
	import pfe_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

FILE: sv/pfe_front.sv
module pfe_front (
	pfe_in_if.sink            item,
	input  pfe_pkg::q_status_t qstat,
	output logic              push,
	output pfe_pkg::cmd_t     cmd
);
	import pfe_pkg::*;

	logic fire;

	assign item.ready = qstat.not_full;
	assign fire       = item.valid && qstat.not_full;

	always_comb begin
		push      = 1'b0;
		cmd.kind  = CMD_FIELD;
		cmd.key   = {item.fnum, WIRE_VARINT};
		cmd.value = item.value;
		case (func_t'(item.func))
			FUNC_VARINT: begin
				push = fire;
			end
			FUNC_LEN: begin
				cmd.key = {item.fnum, WIRE_LEN};
				push    = fire;
			end
			FUNC_BYTE: begin
				cmd.kind  = CMD_BYTE;
				cmd.value = VALUE_W'(item.payload_byte);
				push      = fire;
			end
			default: begin
				// drop unused code
				push = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/pfe_queue.sv
module pfe_queue #(
	parameter int DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pfe_pkg::cmd_t      wdata,
	input  logic               pop,
	output pfe_pkg::cmd_t      rdata,
	output pfe_pkg::q_status_t qstat
);
	import pfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.not_empty = (cnt_q != '0);
	assign qstat.not_full  = (cnt_q != CNT_W'(DEPTH));
	assign do_push         = push && qstat.not_full;
	assign do_pop          = pop && qstat.not_empty;
	assign rdata           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

FILE: sv/pfe_back.sv
module pfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pfe_pkg::cmd_t      head,
	input  pfe_pkg::q_status_t qstat,
	output logic               pop,
	pfe_out_if.source          beat
);
	import pfe_pkg::*;

	ser_state_t         state_q;
	ser_state_t         state_d;
	logic [VALUE_W-1:0] sh_q;
	logic [VALUE_W-1:0] sh_d;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] val_d;
	logic               ovalid_q;
	logic [BYTE_W-1:0]  obyte_q;
	logic               olast_q;

	logic               can_load;
	logic [VALUE_W-1:0] src;
	logic [VALUE_W-1:0] rest;
	logic               more;
	logic               emit;
	logic [BYTE_W-1:0]  emit_byte;
	logic               emit_last;

	assign beat.valid    = ovalid_q;
	assign beat.out_byte = obyte_q;
	assign beat.last     = olast_q;

	assign can_load = !ovalid_q || beat.ready;
	assign src      = (state_q == ST_IDLE) ? VALUE_W'(head.key) : sh_q;
	assign more     = |src[VALUE_W-1:GROUP_W];
	assign rest     = src >> GROUP_W;

	always_comb begin
		state_d   = state_q;
		sh_d      = sh_q;
		val_d     = val_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = {more, src[GROUP_W-1:0]};
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (qstat.not_empty && can_load) begin
					pop  = 1'b1;
					emit = 1'b1;
					if (head.kind == CMD_BYTE) begin
						emit_byte = head.value[BYTE_W-1:0];
						emit_last = 1'b1;
					end else begin
						val_d = head.value;
						if (more) begin
							sh_d    = rest;
							state_d = ST_KEY;
						end else begin
							sh_d    = head.value;
							state_d = ST_VAL;
						end
					end
				end
			end
			ST_KEY: begin
				if (can_load) begin
					emit = 1'b1;
					if (more) begin
						sh_d = rest;
					end else begin
						sh_d    = val_q;
						state_d = ST_VAL;
					end
				end
			end
			ST_VAL: begin
				if (can_load) begin
					emit = 1'b1;
					if (more) begin
						sh_d = rest;
					end else begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (beat.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sh_q  <= sh_d;
		val_q <= val_d;
		if (emit) begin
			obyte_q <= emit_byte;
			olast_q <= emit_last;
		end
	end

endmodule

FILE: sv/protobuf_field_encoder_top.sv
// Protobuf-3 field encoder. Each item on "item" is a varint field, a length-delimited
// header or one payload byte; "beat" carries the encoded stream one byte per beat,
// with last high on the final byte of each item. Field items emit the key varint
// (field number << 3 | wire type) and then the value varint, least significant
// group first, so they take 2 to 10 bytes; payload items take 1 byte; unused
// func codes are accepted and dropped. The back end serializer emits one byte per
// cycle while the stream is ready and sets the rate; a short command queue lets the
// input side keep accepting items while the serializer works or the stream stalls.
module protobuf_field_encoder_top #(
	parameter int QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pfe_in_if.sink    item,
	pfe_out_if.source beat
);
	import pfe_pkg::*;

	q_status_t qstat;
	cmd_t      push_cmd;
	cmd_t      head;
	logic      push;
	logic      pop;

	pfe_front u_front (
		.item  (item),
		.qstat (qstat),
		.push  (push),
		.cmd   (push_cmd)
	);

	pfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head),
		.qstat  (qstat)
	);

	pfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.beat   (beat)
	);

endmodule

FILE: sv/pfe_checker.sv
module pfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       beat_valid,
	input logic       beat_ready,
	input logic [7:0] beat_byte,
	input logic       beat_last
);
	logic [3:0] cnt_q;
	logic       key_done_q;
	logic       taken;

	assign taken = beat_valid && beat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			key_done_q <= 1'b0;
		end else if (taken) begin
			if (beat_last) begin
				cnt_q      <= '0;
				key_done_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				if (!beat_byte[7]) begin
					key_done_q <= 1'b1;
				end
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && !beat_ready |=> beat_valid && $stable(beat_byte) && $stable(beat_last))
		else $error("beat changed while stalled");

	a_max_ten: assert property (@(posedge clk) disable iff (!arst_n)
		taken && cnt_q == 4'd9 |-> beat_last)
		else $error("item longer than ten bytes");

	a_one_key_end: assert property (@(posedge clk) disable iff (!arst_n)
		taken && !beat_last && !beat_byte[7] |-> !key_done_q)
		else $error("second varint end inside one item");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !beat_valid)
		else $error("beat valid during reset");

endmodule

bind protobuf_field_encoder_top pfe_checker u_pfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.beat_valid (beat.valid),
	.beat_ready (beat.ready),
	.beat_byte  (beat.out_byte),
	.beat_last  (beat.last)
);

FILE: tb/protobuf_field_encoder_top_tb.sv
module protobuf_field_encoder_top_tb;
	import pfe_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int BY_MODEL     = -1;
	localparam int SETTLE       = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int ITEMS_PHASE  = 67;
	localparam int N_DIR        = 18;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} enc_byte_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FNUM_W-1:0]  fnum;
		logic [VALUE_W-1:0] value;
		logic [BYTE_W-1:0]  pbyte;
		int                 n_bytes;
		logic [79:0]        bytes;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pfe_in_if  item_if ();
	pfe_out_if beat_if ();

	protobuf_field_encoder_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.beat   (beat_if)
	);

	enc_byte_t   expected_bytes[$];
	enc_byte_t   head;
	int          mismatch_cnt = 0;
	int unsigned cycle_cnt    = 0;
	int          tx_idle_pct  = 0;
	int          rx_idle_pct  = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{FUNC_VARINT, 28'd1,         32'd0,          8'h00, 2,  80'h0008},
		'{FUNC_VARINT, 28'd0,         32'd0,          8'h00, 2,  80'h0000},
		'{FUNC_VARINT, 28'h0FFFFFFF,  32'hFFFFFFFF,   8'hFF, 10,
			80'h0FFF_FFFF_FF07_FFFF_FFF8},
		'{FUNC_LEN,    28'd2,         32'd3,          8'h00, 2,  80'h0312},
		'{FUNC_BYTE,   28'd0,         32'd0,          8'h00, 1,  80'h00},
		'{FUNC_BYTE,   28'd0,         32'd0,          8'hFF, 1,  80'hFF},
		'{FUNC_BYTE,   28'h0FFFFFFF,  32'hFFFFFFFF,   8'hA5, 1,  80'hA5},
		'{FUNC_UNUSED, 28'h0FFFFFFF,  32'hFFFFFFFF,   8'hFF, 0,  80'h0},
		'{FUNC_VARINT, 28'd15,        32'd127,        8'h00, 2,  80'h7F78},
		'{FUNC_VARINT, 28'd16,        32'd128,        8'h00, 4,  80'h0180_0180},
		'{FUNC_LEN,    28'h0FFFFFFF,  32'd0,          8'h00, 6,  80'h0007_FFFF_FFFA},
		'{FUNC_VARINT, 28'd1,         32'h80000000,   8'h00, 6,  80'h0880_8080_8008},
		'{FUNC_LEN,    28'd1,         32'd300,        8'h00, 3,  80'h02AC0A},
		'{FUNC_VARINT, 28'd5,         32'h7FFFFFFF,   8'h3C, BY_MODEL, 80'h0},
		'{FUNC_LEN,    28'h0AAAAAAA,  32'h55555555,   8'hC3, BY_MODEL, 80'h0},
		'{FUNC_VARINT, 28'h05555555,  32'hAAAAAAAA,   8'h00, BY_MODEL, 80'h0},
		'{FUNC_BYTE,   28'h05555555,  32'h0,          8'h5A, BY_MODEL, 80'h0},
		'{FUNC_UNUSED, 28'd0,         32'd0,          8'h00, 0,  80'h0}
	};

	function automatic void push_varint(input logic [31:0] v, input logic mark_last);
		logic [31:0] rest;
		rest = v;
		while (rest > 32'd127) begin
			expected_bytes.push_back('{8'h80 | {1'b0, rest[6:0]}, 1'b0});
			rest = rest >> GROUP_W;
		end
		expected_bytes.push_back('{rest[7:0], mark_last});
	endfunction

	function automatic void predict_encoding(input logic [FUNC_W-1:0] func,
		input logic [FNUM_W-1:0] fnum, input logic [VALUE_W-1:0] value,
		input logic [BYTE_W-1:0] pbyte);
		logic [31:0] key;
		if (func == FUNC_VARINT || func == FUNC_LEN) begin
			key = {1'b0, fnum, (func == FUNC_VARINT) ? WIRE_VARINT : WIRE_LEN};
			push_varint(key, 1'b0);
			push_varint(value, 1'b1);
		end else if (func == FUNC_BYTE) begin
			expected_bytes.push_back('{pbyte, 1'b1});
		end
	endfunction

	function automatic logic [31:0] rand_bits(input int w);
		logic [63:0] mask;
		if ($urandom_range(0, 9) == 0)
			mask = (64'd1 << w) - 1;
		else
			mask = (64'd1 << $urandom_range(0, w)) - 1;
		return $urandom & mask[31:0];
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		beat_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			beat_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && beat_if.valid && beat_if.ready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected beat: out_byte %02h last %0b",
					beat_if.out_byte, beat_if.last);
				mismatch_cnt++;
			end else begin
				head = expected_bytes.pop_front();
				if (beat_if.out_byte !== head.out_byte) begin
					$error("out_byte mismatch: expected %02h, got %02h",
						head.out_byte, beat_if.out_byte);
					mismatch_cnt++;
				end
				if (beat_if.last !== head.last) begin
					$error("last mismatch: expected %0b, got %0b",
						head.last, beat_if.last);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_item(input logic [FUNC_W-1:0] func, input logic [FNUM_W-1:0] fnum,
		input logic [VALUE_W-1:0] value, input logic [BYTE_W-1:0] pbyte,
		input int n_typed, input logic [79:0] typed);
		int i;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid        <= 1'b1;
		item_if.func         <= func;
		item_if.fnum         <= fnum;
		item_if.value        <= value;
		item_if.payload_byte <= pbyte;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		if (n_typed < 0) begin
			predict_encoding(func, fnum, value, pbyte);
		end else begin
			for (i = 0; i < n_typed; i++)
				expected_bytes.push_back('{typed[8*i +: 8], i == n_typed - 1});
		end
	endtask

	task automatic hold_until_drained();
		item_if.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic drain_and_settle();
		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_random(input int n_items);
		int sent;
		int pick;
		int len;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 3)
				hold_until_drained();
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				len = $urandom_range(0, 6);
				send_item(FUNC_LEN, FNUM_W'(rand_bits(FNUM_W)), len, BYTE_W'($urandom),
					BY_MODEL, 80'h0);
				for (k = 0; k < len; k++)
					send_item(FUNC_BYTE, FNUM_W'($urandom), $urandom, BYTE_W'($urandom),
						BY_MODEL, 80'h0);
				sent += len + 1;
			end else if (pick < 55) begin
				send_item(FUNC_VARINT, FNUM_W'(rand_bits(FNUM_W)), rand_bits(VALUE_W),
					BYTE_W'($urandom), BY_MODEL, 80'h0);
				sent++;
			end else if (pick < 72) begin
				send_item(FUNC_LEN, FNUM_W'(rand_bits(FNUM_W)), rand_bits(VALUE_W),
					BYTE_W'($urandom), BY_MODEL, 80'h0);
				sent++;
			end else if (pick < 92) begin
				send_item(FUNC_BYTE, FNUM_W'($urandom), $urandom, BYTE_W'($urandom),
					BY_MODEL, 80'h0);
				sent++;
			end else begin
				send_item(FUNC_UNUSED, FNUM_W'($urandom), $urandom, BYTE_W'($urandom),
					0, 80'h0);
			end
		end
	endtask

	initial begin
		int r;
		arst_n               <= 1'b0;
		item_if.valid        <= 1'b0;
		item_if.func         <= FUNC_VARINT;
		item_if.fnum         <= '0;
		item_if.value        <= '0;
		item_if.payload_byte <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 26;
		rx_idle_pct = 53;
		for (r = 0; r < N_DIR; r++)
			send_item(dir_rows[r].func, dir_rows[r].fnum, dir_rows[r].value,
				dir_rows[r].pbyte, dir_rows[r].n_bytes, dir_rows[r].bytes);
		send_random(ITEMS_PHASE);
		drain_and_settle();

		tx_idle_pct = 53;
		rx_idle_pct = 26;
		send_random(ITEMS_PHASE);
		drain_and_settle();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(ITEMS_PHASE);
		drain_and_settle();

		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
sv/pfe_pkg.sv
sv/pfe_ifs.sv
sv/pfe_front.sv
sv/pfe_queue.sv
sv/pfe_back.sv
sv/protobuf_field_encoder_top.sv
sv/pfe_checker.sv
tb/protobuf_field_encoder_top_tb.sv
